/* rtl/isotp_rx_pkg.sv */
// types, codes and constants shared by the iso-tp receive reassembly block
package isotp_rx_pkg;

  localparam logic [1:0] REQ_ARM   = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_FC    = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_BAD_SF    = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_SEQ       = 3'd4;
  localparam logic [2:0] ST_BAD_FF    = 3'd5;

  localparam logic       CFG_RESPONSE_ID = 1'b0;
  localparam logic       CFG_TIMEOUT     = 1'b1;

  localparam logic [63:0] FC_CTS_BYTES   = 64'h30;
  localparam logic [10:0] FC_ID_OFFSET   = 11'd8;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [10:0] RESP_ID_RESET  = 11'd0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [3:0]  SEQ_FIRST      = 4'd1;
  localparam logic [11:0] FF_BYTES       = 12'd6;
  localparam logic [11:0] CF_BYTES       = 12'd7;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ARMED,
    MODE_RECV
  } mode_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_FIN,
    TAIL_FC
  } tail_t;

  typedef struct packed {
    logic        chunk_valid;
    logic [55:0] payload;
    logic [2:0]  count;
    tail_t       tail;
    logic [2:0]  status;
    logic [11:0] mlen;
    logic [10:0] fc_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [55:0] payload;
    logic [2:0]  count;
    logic [10:0] fc_id;
    logic [63:0] fc_bytes;
    logic [2:0]  status;
    logic [11:0] mlen;
    logic        last;
  } res_t;

endpackage

/* rtl/isotp_rx_front.sv */
// front part: configuration registers, frame classification and reassembly state
module isotp_rx_front #(
  parameter int MAX_MESSAGE_BYTES = 4095
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [10:0]          in_frame_id,
  input  logic [63:0]          in_frame_bytes,
  input  logic                 q_full,
  output logic                 q_push,
  output isotp_rx_pkg::cmd_t   q_cmd
);

  localparam logic [11:0] MaxLen = 12'(MAX_MESSAGE_BYTES);

  isotp_rx_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [3:0]  next_seq_r, next_seq_nxt;
  logic [11:0] remaining_r, remaining_nxt;
  logic [11:0] total_r, total_nxt;
  logic [10:0] response_id_r;
  logic [15:0] timeout_r;

  logic        accept;
  logic        is_frame;
  logic [3:0]  pci_hi;
  logic [3:0]  pci_lo;
  logic [11:0] ff_len;
  logic [15:0] elapsed_inc;
  logic [11:0] cf_n;
  logic [11:0] rem_after;

  function automatic logic [55:0] chunk_bytes(input logic [63:0] fb, input logic [2:0] n);
    logic [55:0] r;
    r = '0;
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < n) r[i*8 +: 8] = fb[8 + i*8 +: 8];
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_frame = (in_req_type == isotp_rx_pkg::REQ_FRAME) && (mode_r != isotp_rx_pkg::MODE_IDLE)
                    && (in_frame_id == response_id_r);
  assign pci_hi   = in_frame_bytes[7:4];
  assign pci_lo   = in_frame_bytes[3:0];
  assign ff_len   = {pci_lo, in_frame_bytes[15:8]};
  assign elapsed_inc = (elapsed_r == isotp_rx_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
  assign cf_n      = (remaining_r < isotp_rx_pkg::CF_BYTES) ? remaining_r : isotp_rx_pkg::CF_BYTES;
  assign rem_after = remaining_r - cf_n;

  // next state
  always_comb begin
    mode_nxt      = mode_r;
    elapsed_nxt   = elapsed_r;
    next_seq_nxt  = next_seq_r;
    remaining_nxt = remaining_r;
    total_nxt     = total_r;
    if (accept) begin
      case (in_req_type)
        isotp_rx_pkg::REQ_ARM: begin
          mode_nxt      = isotp_rx_pkg::MODE_ARMED;
          elapsed_nxt   = '0;
          next_seq_nxt  = isotp_rx_pkg::SEQ_FIRST;
          remaining_nxt = '0;
          total_nxt     = '0;
        end
        isotp_rx_pkg::REQ_TICK: begin
          if (mode_r != isotp_rx_pkg::MODE_IDLE) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_r) mode_nxt = isotp_rx_pkg::MODE_IDLE;
          end
        end
        isotp_rx_pkg::REQ_FRAME: begin
          if (is_frame && mode_r == isotp_rx_pkg::MODE_ARMED) begin
            if (pci_hi == isotp_rx_pkg::PCI_SF) begin
              mode_nxt = isotp_rx_pkg::MODE_IDLE;
            end else if (pci_hi == isotp_rx_pkg::PCI_FF) begin
              if (ff_len > MaxLen || ff_len <= isotp_rx_pkg::FF_BYTES) begin
                mode_nxt = isotp_rx_pkg::MODE_IDLE;
              end else begin
                mode_nxt      = isotp_rx_pkg::MODE_RECV;
                total_nxt     = ff_len;
                remaining_nxt = ff_len - isotp_rx_pkg::FF_BYTES;
                next_seq_nxt  = isotp_rx_pkg::SEQ_FIRST;
                elapsed_nxt   = '0;
              end
            end
          end else if (is_frame && mode_r == isotp_rx_pkg::MODE_RECV
                       && pci_hi == isotp_rx_pkg::PCI_CF) begin
            if (pci_lo != next_seq_r) begin
              mode_nxt = isotp_rx_pkg::MODE_IDLE;
            end else begin
              remaining_nxt = rem_after;
              next_seq_nxt  = next_seq_r + 4'd1;
              if (rem_after == '0) mode_nxt = isotp_rx_pkg::MODE_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // command to the back part
  always_comb begin
    q_push            = 1'b0;
    q_cmd             = '0;
    q_cmd.tail        = isotp_rx_pkg::TAIL_FIN;
    q_cmd.fc_id       = response_id_r - isotp_rx_pkg::FC_ID_OFFSET;
    if (accept) begin
      case (in_req_type)
        isotp_rx_pkg::REQ_TICK: begin
          if (mode_r != isotp_rx_pkg::MODE_IDLE && elapsed_inc >= timeout_r) begin
            q_push       = 1'b1;
            q_cmd.status = isotp_rx_pkg::ST_TIMEOUT;
          end
        end
        isotp_rx_pkg::REQ_FRAME: begin
          if (is_frame && mode_r == isotp_rx_pkg::MODE_ARMED) begin
            if (pci_hi == isotp_rx_pkg::PCI_SF) begin
              q_push = 1'b1;
              if (pci_lo > 4'd7) begin
                q_cmd.status = isotp_rx_pkg::ST_BAD_SF;
              end else begin
                q_cmd.chunk_valid = (pci_lo != 4'd0);
                q_cmd.payload     = chunk_bytes(in_frame_bytes, pci_lo[2:0]);
                q_cmd.count       = pci_lo[2:0];
                q_cmd.mlen        = {8'd0, pci_lo};
              end
            end else if (pci_hi == isotp_rx_pkg::PCI_FF) begin
              q_push = 1'b1;
              if (ff_len > MaxLen) begin
                q_cmd.status = isotp_rx_pkg::ST_TOO_LONG;
              end else if (ff_len <= isotp_rx_pkg::FF_BYTES) begin
                q_cmd.status = isotp_rx_pkg::ST_BAD_FF;
              end else begin
                q_cmd.chunk_valid = 1'b1;
                q_cmd.payload     = {8'd0, in_frame_bytes[63:16]};
                q_cmd.count       = 3'd6;
                q_cmd.tail        = isotp_rx_pkg::TAIL_FC;
              end
            end
          end else if (is_frame && mode_r == isotp_rx_pkg::MODE_RECV
                       && pci_hi == isotp_rx_pkg::PCI_CF) begin
            q_push = 1'b1;
            if (pci_lo != next_seq_r) begin
              q_cmd.status = isotp_rx_pkg::ST_SEQ;
            end else begin
              q_cmd.chunk_valid = 1'b1;
              q_cmd.payload     = chunk_bytes(in_frame_bytes, cf_n[2:0]);
              q_cmd.count       = cf_n[2:0];
              if (rem_after == '0) begin
                q_cmd.mlen = total_r;
              end else begin
                q_cmd.tail = isotp_rx_pkg::TAIL_NONE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= isotp_rx_pkg::MODE_IDLE;
      elapsed_r     <= '0;
      next_seq_r    <= isotp_rx_pkg::SEQ_FIRST;
      remaining_r   <= '0;
      total_r       <= '0;
      response_id_r <= isotp_rx_pkg::RESP_ID_RESET;
      timeout_r     <= isotp_rx_pkg::TIMEOUT_RESET;
    end else begin
      mode_r      <= mode_nxt;
      elapsed_r   <= elapsed_nxt;
      next_seq_r  <= next_seq_nxt;
      remaining_r <= remaining_nxt;
      total_r     <= total_nxt;
      if (cfg_we) begin
        case (cfg_index)
          isotp_rx_pkg::CFG_RESPONSE_ID: response_id_r <= cfg_wdata[10:0];
          isotp_rx_pkg::CFG_TIMEOUT:     timeout_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/isotp_rx_queue.sv */
// short command queue between the front and back parts
module isotp_rx_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  isotp_rx_pkg::cmd_t   push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output isotp_rx_pkg::cmd_t   head_cmd
);

  isotp_rx_pkg::cmd_t store_r [isotp_rx_pkg::Q_DEPTH];
  logic [isotp_rx_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [isotp_rx_pkg::Q_CNT_W-1:0] count_r;

  assign full     = (count_r == isotp_rx_pkg::Q_CNT_W'(isotp_rx_pkg::Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/isotp_rx_back.sv */
// back part: expands queued commands into result words through an output register
module isotp_rx_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  isotp_rx_pkg::cmd_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output isotp_rx_pkg::res_t   out_res
);

  logic               out_valid_r, out_valid_nxt;
  isotp_rx_pkg::res_t res_r, res_nxt;
  logic               pend_r, pend_nxt;
  isotp_rx_pkg::cmd_t held_r, held_nxt;
  logic               load;

  function automatic isotp_rx_pkg::res_t tail_res(input isotp_rx_pkg::cmd_t c);
    isotp_rx_pkg::res_t r;
    r      = '0;
    r.last = 1'b1;
    if (c.tail == isotp_rx_pkg::TAIL_FC) begin
      r.kind     = isotp_rx_pkg::KIND_FC;
      r.fc_id    = c.fc_id;
      r.fc_bytes = isotp_rx_pkg::FC_CTS_BYTES;
    end else begin
      r.kind   = isotp_rx_pkg::KIND_DONE;
      r.status = c.status;
      r.mlen   = c.mlen;
    end
    return r;
  endfunction

  function automatic isotp_rx_pkg::res_t chunk_res(input isotp_rx_pkg::cmd_t c);
    isotp_rx_pkg::res_t r;
    r         = '0;
    r.kind    = isotp_rx_pkg::KIND_CHUNK;
    r.payload = c.payload;
    r.count   = c.count;
    r.last    = (c.tail == isotp_rx_pkg::TAIL_NONE);
    return r;
  endfunction

  assign load      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    held_nxt      = held_r;
    q_pop         = 1'b0;
    if (load) begin
      if (pend_r) begin
        res_nxt       = tail_res(held_r);
        out_valid_nxt = 1'b1;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        held_nxt      = q_head;
        if (q_head.chunk_valid) begin
          res_nxt  = chunk_res(q_head);
          pend_nxt = (q_head.tail != isotp_rx_pkg::TAIL_NONE);
        end else begin
          res_nxt = tail_res(q_head);
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

/* rtl/isotp_receive_reassembly_top.sv */
// top level of the iso-tp receive reassembly block
// the first result word of a taken input word passes the command queue, then the output register
// the second result word of a frame is loaded from the held command once the first is taken
// throughput: one input word a cycle while in_stall is low; no pop between a word's two results
// the back part's single output register sets the rate of one result word a cycle unless stalled
// reset: synchronous, active low; clears mode, counters, queue and output, loads register defaults
module isotp_receive_reassembly_top #(
  parameter int MAX_MESSAGE_BYTES = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [10:0] in_frame_id,
  input  logic [63:0] in_frame_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [55:0] out_payload,
  output logic [2:0]  out_payload_count,
  output logic [10:0] out_fc_can_id,
  output logic [63:0] out_fc_bytes,
  output logic [2:0]  out_status,
  output logic [11:0] out_message_len,
  output logic        out_last
);

  logic               q_full, q_push, q_pop, q_empty;
  isotp_rx_pkg::cmd_t q_cmd, q_head;
  isotp_rx_pkg::res_t res;

  isotp_rx_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_frame_id    (in_frame_id),
    .in_frame_bytes (in_frame_bytes),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  isotp_rx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head)
  );

  isotp_rx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_result_kind   = res.kind;
  assign out_payload       = res.payload;
  assign out_payload_count = res.count;
  assign out_fc_can_id     = res.fc_id;
  assign out_fc_bytes      = res.fc_bytes;
  assign out_status        = res.status;
  assign out_message_len   = res.mlen;
  assign out_last          = res.last;

endmodule

/* tb/sv/tb_isotp_receive_reassembly_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the iso-tp receive reassembly block, with its scoreboard class

class isotp_rx_scoreboard;
  int unsigned         max_msg_bytes = 4095;
  isotp_rx_pkg::mode_t mode;
  logic [15:0]         elapsed;
  logic [3:0]          next_seq;
  logic [11:0]         remaining;
  logic [11:0]         total;
  logic [10:0]         resp_id;
  logic [15:0]         timeout_ticks;
  isotp_rx_pkg::res_t  due_words[$];
  int                  mismatches;

  function new();
    mode          = isotp_rx_pkg::MODE_IDLE;
    elapsed       = '0;
    next_seq      = isotp_rx_pkg::SEQ_FIRST;
    remaining     = '0;
    total         = '0;
    resp_id       = isotp_rx_pkg::RESP_ID_RESET;
    timeout_ticks = isotp_rx_pkg::TIMEOUT_RESET;
    mismatches    = 0;
  endfunction

  function void set_reg(logic idx, logic [15:0] v);
    if (idx == isotp_rx_pkg::CFG_RESPONSE_ID) begin
      resp_id = v[10:0];
    end else begin
      timeout_ticks = v;
    end
  endfunction

  function logic [55:0] take_bytes(logic [63:0] fb, logic [2:0] n);
    logic [55:0] p;
    p = '0;
    for (int i = 0; i < 7; i++)
      if (i < n) p[8*i +: 8] = fb[8*i+8 +: 8];
    return p;
  endfunction

  function void add(logic [1:0] kind, logic [55:0] pay, logic [2:0] cnt, logic [10:0] fcid,
                    logic [63:0] fcb, logic [2:0] st, logic [11:0] mlen, logic last);
    isotp_rx_pkg::res_t w;
    w.kind     = kind;
    w.payload  = pay;
    w.count    = cnt;
    w.fc_id    = fcid;
    w.fc_bytes = fcb;
    w.status   = st;
    w.mlen     = mlen;
    w.last     = last;
    due_words.push_back(w);
  endfunction

  function void finish(logic [2:0] st, logic [11:0] mlen);
    add(isotp_rx_pkg::KIND_DONE, '0, '0, '0, '0, st, mlen, 1'b1);
    mode = isotp_rx_pkg::MODE_IDLE;
  endfunction

  function void note_word(logic [1:0] req, logic [10:0] fid, logic [63:0] fb);
    bit          busy;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [11:0] len;
    logic [11:0] n;
    busy = (mode != isotp_rx_pkg::MODE_IDLE);
    hi   = fb[7:4];
    lo   = fb[3:0];
    if (req == isotp_rx_pkg::REQ_ARM) begin
      mode      = isotp_rx_pkg::MODE_ARMED;
      elapsed   = '0;
      next_seq  = isotp_rx_pkg::SEQ_FIRST;
      remaining = '0;
      total     = '0;
      return;
    end
    if (req == isotp_rx_pkg::REQ_TICK) begin
      if (busy) begin
        if (elapsed != isotp_rx_pkg::ELAPSED_MAX) elapsed++;
        if (elapsed >= timeout_ticks) finish(isotp_rx_pkg::ST_TIMEOUT, '0);
      end
      return;
    end
    if (req != isotp_rx_pkg::REQ_FRAME || !busy || fid != resp_id) return;
    if (mode == isotp_rx_pkg::MODE_ARMED) begin
      if (hi == isotp_rx_pkg::PCI_SF) begin
        if (lo > 4'd7) begin
          finish(isotp_rx_pkg::ST_BAD_SF, '0);
        end else begin
          if (lo != 4'd0)
            add(isotp_rx_pkg::KIND_CHUNK, take_bytes(fb, lo[2:0]), lo[2:0], '0, '0,
                isotp_rx_pkg::ST_OK, '0, 1'b0);
          finish(isotp_rx_pkg::ST_OK, {8'd0, lo});
        end
      end else if (hi == isotp_rx_pkg::PCI_FF) begin
        len = {lo, fb[15:8]};
        if (len > max_msg_bytes) begin
          finish(isotp_rx_pkg::ST_TOO_LONG, '0);
        end else if (len <= isotp_rx_pkg::FF_BYTES) begin
          finish(isotp_rx_pkg::ST_BAD_FF, '0);
        end else begin
          add(isotp_rx_pkg::KIND_CHUNK, {8'd0, fb[63:16]}, isotp_rx_pkg::FF_BYTES[2:0], '0, '0,
              isotp_rx_pkg::ST_OK, '0, 1'b0);
          add(isotp_rx_pkg::KIND_FC, '0, '0, resp_id - isotp_rx_pkg::FC_ID_OFFSET,
              isotp_rx_pkg::FC_CTS_BYTES, isotp_rx_pkg::ST_OK, '0, 1'b1);
          mode      = isotp_rx_pkg::MODE_RECV;
          total     = len;
          remaining = len - isotp_rx_pkg::FF_BYTES;
          next_seq  = isotp_rx_pkg::SEQ_FIRST;
          elapsed   = '0;
        end
      end
    end else if (hi == isotp_rx_pkg::PCI_CF) begin
      if (lo != next_seq) begin
        finish(isotp_rx_pkg::ST_SEQ, '0);
      end else begin
        n = (remaining < isotp_rx_pkg::CF_BYTES) ? remaining : isotp_rx_pkg::CF_BYTES;
        remaining -= n;
        next_seq++;
        add(isotp_rx_pkg::KIND_CHUNK, take_bytes(fb, n[2:0]), n[2:0], '0, '0,
            isotp_rx_pkg::ST_OK, '0, remaining != 12'd0);
        if (remaining == 12'd0) finish(isotp_rx_pkg::ST_OK, total);
      end
    end
  endfunction

  function string show(isotp_rx_pkg::res_t w);
    return $sformatf("kind=%0d pay=%h cnt=%0d fcid=%h fcb=%h st=%0d len=%0d last=%0b",
                     w.kind, w.payload, w.count, w.fc_id, w.fc_bytes, w.status, w.mlen, w.last);
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function void check_result(isotp_rx_pkg::res_t got);
    isotp_rx_pkg::res_t want;
    if (due_words.size() == 0) begin
      flag({"unexpected word ", show(got)});
      return;
    end
    want = due_words.pop_front();
    if (got.kind !== want.kind || got.payload !== want.payload || got.count !== want.count ||
        got.fc_id !== want.fc_id || got.fc_bytes !== want.fc_bytes ||
        got.status !== want.status || got.mlen !== want.mlen || got.last !== want.last)
      flag({"expected ", show(want), " got ", show(got)});
  endfunction
endclass

module tb_isotp_receive_reassembly_top;
  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam int         QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [10:0] in_frame_id;
  logic [63:0] in_frame_bytes;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [55:0] out_payload;
  logic [2:0]  out_payload_count;
  logic [10:0] out_fc_can_id;
  logic [63:0] out_fc_bytes;
  logic [2:0]  out_status;
  logic [11:0] out_message_len;
  logic        out_last;

  isotp_rx_scoreboard sb;
  isotp_rx_pkg::res_t seen_word;
  bit   calm;
  int   words_done;
  int   quiet_cycles = 0;

  isotp_receive_reassembly_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_frame_id(in_frame_id), .in_frame_bytes(in_frame_bytes),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_payload(out_payload), .out_payload_count(out_payload_count),
    .out_fc_can_id(out_fc_can_id), .out_fc_bytes(out_fc_bytes), .out_status(out_status),
    .out_message_len(out_message_len), .out_last(out_last)
  );

  assign seen_word = {out_result_kind, out_payload, out_payload_count, out_fc_can_id,
                      out_fc_bytes, out_status, out_message_len, out_last};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 24);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(seen_word);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_isotp_receive_reassembly_top NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] frame_sf(logic [3:0] len, logic [55:0] data);
    return {data, isotp_rx_pkg::PCI_SF, len};
  endfunction

  function automatic logic [63:0] frame_ff(logic [11:0] len, logic [47:0] data);
    return {data, len[7:0], isotp_rx_pkg::PCI_FF, len[11:8]};
  endfunction

  function automatic logic [63:0] frame_cf(logic [3:0] seq, logic [55:0] data);
    return {data, isotp_rx_pkg::PCI_CF, seq};
  endfunction

  task automatic send_word(logic [1:0] req, logic [10:0] fid, logic [63:0] fb);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_req_type    = req;
    in_frame_id    = fid;
    in_frame_bytes = fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(req, fid, fb);
    words_done++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_frame(logic [63:0] fb);
    send_word(isotp_rx_pkg::REQ_FRAME, sb.resp_id, fb);
  endtask

  task automatic write_reg(logic idx, logic [15:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_message(bit big);
    logic [11:0] len;
    logic [3:0]  seq;
    int          left;
    int          r;
    send_word(isotp_rx_pkg::REQ_ARM, 11'($urandom_range(2047)), rand_bytes());
    if (!big && $urandom_range(99) < 30) begin
      len = ($urandom_range(99) < 10) ? 12'($urandom_range(8, 15)) : 12'($urandom_range(7));
      send_frame(frame_sf(len[3:0], rand_bytes()));
    end else begin
      r = $urandom_range(99);
      if (big) len = 12'd4095;
      else if (r < 5) len = 12'($urandom_range(6));
      else if (r < 15) len = 12'($urandom_range(41, 600));
      else len = 12'($urandom_range(7, 40));
      send_frame(frame_ff(len, rand_bytes()));
      left = (len > 12'd6) ? int'(len) - 6 : 0;
      seq  = isotp_rx_pkg::SEQ_FIRST;
      while (left > 0) begin
        r = $urandom_range(99);
        if (r < 8) begin
          send_word(isotp_rx_pkg::REQ_TICK, 11'($urandom_range(2047)), rand_bytes());
        end else if (r < 12) begin
          send_word(isotp_rx_pkg::REQ_FRAME, 11'($urandom_range(2047)), rand_bytes());
        end else if (r < 14) begin
          send_frame(frame_cf(seq + 4'($urandom_range(1, 15)), rand_bytes()));
          left = 0;
        end else begin
          send_frame(frame_cf(seq, rand_bytes()));
          seq++;
          left -= (left < 7) ? left : 7;
        end
      end
    end
  endtask

  task automatic random_noise();
    logic [63:0] fb;
    logic [10:0] fid;
    fb = rand_bytes();
    if ($urandom_range(99) < 70) fb[7:6] = 2'b00;
    case ($urandom_range(2))
      0: fid = sb.resp_id;
      1: fid = 11'($urandom_range(2047));
      default: fid = sb.resp_id ^ (11'd1 << $urandom_range(10));
    endcase
    send_word(2'($urandom_range(3)), fid, fb);
  endtask

  task automatic run_phase(logic [10:0] rid, logic [15:0] ticks, int n, bit quiet_run, bit big);
    logic [15:0] v;
    int          goal;
    v       = 16'($urandom);
    v[10:0] = rid;
    write_reg(isotp_rx_pkg::CFG_RESPONSE_ID, v);
    write_reg(isotp_rx_pkg::CFG_TIMEOUT, ticks);
    calm = quiet_run;
    goal = words_done + n;
    if (big) random_message(1'b1);
    while (words_done < goal) begin
      if ($urandom_range(99) < 75) random_message(1'b0);
      else random_noise();
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = isotp_rx_pkg::CFG_RESPONSE_ID;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_req_type    = isotp_rx_pkg::REQ_ARM;
    in_frame_id    = '0;
    in_frame_bytes = '0;
    out_stall      = 1'b0;
    calm           = 1'b0;
    words_done     = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed part: response id 5 so the flow control id wraps
    write_reg(isotp_rx_pkg::CFG_RESPONSE_ID, 16'h0005);
    write_reg(isotp_rx_pkg::CFG_TIMEOUT, 16'd4);
    send_word(isotp_rx_pkg::REQ_FRAME, 11'h005, '1);
    send_word(isotp_rx_pkg::REQ_TICK, 11'h000, '0);
    send_word(REQ_NONE, 11'h7FF, '1);
    send_word(isotp_rx_pkg::REQ_ARM, 11'h000, '0);
    send_word(isotp_rx_pkg::REQ_FRAME, 11'h000, frame_sf(4'd3, '1));
    send_word(isotp_rx_pkg::REQ_FRAME, 11'h7FF, frame_sf(4'd3, '1));
    send_frame(frame_sf(4'd0, '1));
    send_word(isotp_rx_pkg::REQ_ARM, 11'h7FF, '1);
    send_frame(frame_sf(4'd7, '1));
    send_word(isotp_rx_pkg::REQ_ARM, 11'h005, '0);
    send_frame(frame_sf(4'd15, '0));
    send_word(isotp_rx_pkg::REQ_ARM, 11'h005, '0);
    send_frame(frame_ff(12'd6, '1));
    send_word(isotp_rx_pkg::REQ_ARM, 11'h005, '0);
    send_frame({56'd0, 8'h30});
    send_frame(frame_cf(isotp_rx_pkg::SEQ_FIRST, '1));
    send_frame(frame_ff(12'd4095, '0));
    send_frame(frame_ff(12'd20, '1));
    send_frame(frame_cf(4'd2, '1));
    send_word(isotp_rx_pkg::REQ_ARM, 11'h005, '0);
    send_frame(frame_ff(12'd8, 48'h665544332211));
    repeat (3) send_word(isotp_rx_pkg::REQ_TICK, 11'h005, '0);
    send_frame(frame_cf(isotp_rx_pkg::SEQ_FIRST, '1));
    send_word(isotp_rx_pkg::REQ_ARM, 11'h005, '0);
    repeat (4) send_word(isotp_rx_pkg::REQ_TICK, 11'h005, '0);
    drain();

    run_phase(11'h000, 16'd0, 300, 1'b0, 1'b0);
    run_phase(11'h7FF, 16'hFFFF, 500, 1'b0, 1'b1);
    run_phase(11'($urandom_range(2047)), 16'd3, 300, 1'b0, 1'b0);
    run_phase(11'($urandom_range(2047)), 16'($urandom_range(20, 400)), 400, 1'b1, 1'b0);
    run_phase(11'($urandom_range(2047)), isotp_rx_pkg::TIMEOUT_RESET, 300, 1'b0, 1'b0);

    drain();
    if (sb.mismatches == 0) begin
      $display("tb_isotp_receive_reassembly_top OK");
    end else begin
      $display("tb_isotp_receive_reassembly_top NOT OK");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/isotp_rx_pkg.sv
rtl/isotp_rx_front.sv
rtl/isotp_rx_queue.sv
rtl/isotp_rx_back.sv
rtl/isotp_receive_reassembly_top.sv
tb/sv/tb_isotp_receive_reassembly_top.sv
